>>> design/lsbp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the Lomb-Scargle bin power core.
package lsbp_pkg;

  localparam int BIN_W = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W = 16;
  localparam int STEP_W = 32;
  localparam int POW_W = 48;
  localparam int FREQ_W = 48;
  localparam int MAX_BINS = 65535;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W = 8;
  localparam int IN_TDATA_W = 144;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP = 8'd1;

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 16'd2;
  localparam logic [STEP_W-1:0] FREQ_STEP_RST = 32'd65536;

  typedef struct packed {
    logic                     bin_bad;
    logic [FREQ_W-1:0]        freq;
    logic [2*DATA_W-1:0]      wr_sq;
    logic [2*DATA_W-1:0]      wi_sq;
    logic                     wr_neg;
    logic signed [DATA_W-1:0] wi;
    logic signed [DATA_W-1:0] dr;
    logic signed [DATA_W-1:0] di;
  } fe_item_t;

endpackage

>>> design/lsbp_front.sv
`timescale 1ns / 1ps
// Front end: accepts beats, squares the window parts, forms the frequency and queues items.
module lsbp_front #(
  parameter int QUEUE_DEPTH = lsbp_pkg::QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lsbp_pkg::BIN_W-1:0]             in_bin,
  input  logic signed [lsbp_pkg::DATA_W-1:0]     in_dr,
  input  logic signed [lsbp_pkg::DATA_W-1:0]     in_di,
  input  logic signed [lsbp_pkg::DATA_W-1:0]     in_wr,
  input  logic signed [lsbp_pkg::DATA_W-1:0]     in_wi,
  input  logic [lsbp_pkg::STEP_W-1:0]            freq_step,
  output logic                                   q_valid,
  input  logic                                   q_pop,
  output lsbp_pkg::fe_item_t                     q_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                          f_v_r;
  lsbp_pkg::fe_item_t            f_item_r;
  lsbp_pkg::fe_item_t            f_item_nxt;
  lsbp_pkg::fe_item_t            q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]              wr_ptr_r;
  logic [PTR_W-1:0]              rd_ptr_r;
  logic [QCNT_W-1:0]             cnt_r;
  logic                          full;
  logic                          accept;
  logic                          push;
  logic                          pop;
  logic signed [2*lsbp_pkg::DATA_W-1:0] wr_prod;
  logic signed [2*lsbp_pkg::DATA_W-1:0] wi_prod;
  logic [lsbp_pkg::FREQ_W-1:0]   freq;

  assign full = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign in_ready = !f_v_r || !full;
  assign accept = in_valid && in_ready;
  assign push = f_v_r && !full;
  assign pop = q_pop && (cnt_r != '0);

  assign wr_prod = in_wr * in_wr;
  assign wi_prod = in_wi * in_wi;
  assign freq = {32'd0, in_bin} * {16'd0, freq_step};

  always_comb begin
    f_item_nxt.bin_bad = (in_bin == '0) || (32'(in_bin) > lsbp_pkg::MAX_BINS);
    f_item_nxt.freq = freq;
    f_item_nxt.wr_sq = $unsigned(wr_prod);
    f_item_nxt.wi_sq = $unsigned(wi_prod);
    f_item_nxt.wr_neg = in_wr[lsbp_pkg::DATA_W-1];
    f_item_nxt.wi = in_wi;
    f_item_nxt.dr = in_dr;
    f_item_nxt.di = in_di;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (accept) begin
      f_v_r <= 1'b1;
    end else if (push) begin
      f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= f_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_item = q_mem[rd_ptr_r];

endmodule

>>> design/lsbp_sqrt_pipe.sv
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage.
module lsbp_sqrt_pipe #(
  parameter int W = 64,
  parameter int TW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   in_x,
  input  logic [TW-1:0]  in_tag,
  output logic           out_valid,
  output logic [W/2-1:0] out_root,
  output logic [TW-1:0]  out_tag
);

  localparam int STEPS = W / 2;

  logic [W-1:0]  x_r [STEPS];
  logic [W-1:0]  res_r [STEPS];
  logic          v_r [STEPS];
  logic [TW-1:0] tag_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
    logic [W-1:0]  x_p;
    logic [W-1:0]  res_p;
    logic          v_p;
    logic [TW-1:0] tag_p;
    logic [W-1:0]  trial;
    logic          fit;

    if (k == 0) begin : g_first
      assign x_p = in_x;
      assign res_p = '0;
      assign v_p = in_valid;
      assign tag_p = in_tag;
    end else begin : g_next
      assign x_p = x_r[k-1];
      assign res_p = res_r[k-1];
      assign v_p = v_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    assign trial = res_p + BIT;
    assign fit = (x_p >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k] <= fit ? x_p - trial : x_p;
        res_r[k] <= fit ? (res_p >> 1) + BIT : res_p >> 1;
        tag_r[k] <= tag_p;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root = res_r[STEPS-1][W/2-1:0];
  assign out_tag = tag_r[STEPS-1];

endmodule

>>> design/lsbp_div_pipe.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module lsbp_div_pipe #(
  parameter int DW = 33,
  parameter int QW = 31,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [TW-1:0] out_tag
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] lq_r [QW];
  logic [DW-1:0] den_r [QW];
  logic          v_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_p;
    logic [QW-1:0] lq_p;
    logic [DW-1:0] den_p;
    logic          v_p;
    logic [TW-1:0] tag_p;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = in_rem;
      assign lq_p = in_low;
      assign den_p = in_den;
      assign v_p = in_valid;
      assign tag_p = in_tag;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign lq_p = lq_r[k-1];
      assign den_p = den_r[k-1];
      assign v_p = v_r[k-1];
      assign tag_p = tag_r[k-1];
    end

    assign trial = {rem_p, lq_p[QW-1]};
    assign ge = (trial >= {1'b0, den_p});
    assign diff = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        lq_r[k] <= {lq_p[QW-2:0], ge};
        den_r[k] <= den_p;
        tag_r[k] <= tag_p;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quot = lq_r[QW-1];
  assign out_tag = tag_r[QW-1];

endmodule

>>> design/lsbp_back.sv
`timescale 1ns / 1ps
// Back end: window angle, projections, normalized terms and the output register.
module lsbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  lsbp_pkg::fe_item_t            q_item,
  input  logic [lsbp_pkg::CNT_W-1:0]    sample_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsbp_pkg::POW_W-1:0]    out_power,
  output logic [lsbp_pkg::FREQ_W-1:0]   out_freq,
  output logic                          out_degen,
  output logic                          out_sat
);

  localparam int DW = lsbp_pkg::DATA_W;
  localparam int FW = lsbp_pkg::FREQ_W;
  localparam int TAG_H = 2 + FW + 3 * DW;
  localparam int TAG_C = 2 * DW;
  localparam int TAG_S = 2 + FW + 66;
  localparam int TAG_T = 2 + FW;
  localparam logic [48:0] TERM_MAX = 49'h1_0000_0000_0000;

  typedef struct packed {
    logic          degen;
    logic [FW-1:0] freq;
    logic [32:0]   d1;
    logic [32:0]   d2;
  } side_t;

  logic en;

  // Magnitude of the window.
  logic                 h_v;
  logic [31:0]          h;
  logic [TAG_H-1:0]     h_tag;
  logic                 h_bad;
  logic [FW-1:0]        h_freq;
  logic                 h_neg;
  logic signed [DW-1:0] h_wi;
  logic signed [DW-1:0] h_dr;
  logic signed [DW-1:0] h_di;

  logic [31:0] n16;
  logic [32:0] d1w;
  logic [33:0] d2w;
  logic [33:0] xc;
  logic [33:0] xs;
  logic        degen;

  logic                 b_v_r;
  logic [32:0]          b_xc_r;
  logic [32:0]          b_xs_r;
  logic [32:0]          b_den_r;
  side_t                b_side_r;
  logic                 b_neg_r;
  logic signed [DW-1:0] b_dr_r;
  logic signed [DW-1:0] b_di_r;

  // Squared cosine and sine quotients and their roots.
  logic             qc_v;
  logic             qs_v;
  logic [30:0]      qc;
  logic [30:0]      qs;
  logic [TAG_C-1:0] qc_tag;
  logic [TAG_S-1:0] qs_tag;
  logic             rc_v;
  logic             rs_v;
  logic [30:0]      cwt;
  logic [30:0]      swt;
  logic [TAG_C-1:0] rc_tag;
  logic [TAG_S-1:0] rs_tag;
  logic signed [DW-1:0] r_dr;
  logic signed [DW-1:0] r_di;
  side_t            r_side;
  logic             r_neg;

  logic               m1_v_r;
  logic signed [63:0] m1_p1_r;
  logic signed [63:0] m1_p2_r;
  logic signed [63:0] m1_p3_r;
  logic signed [63:0] m1_p4_r;
  logic               m1_neg_r;
  side_t              m1_side_r;

  logic               m2_v_r;
  logic signed [63:0] m2_a_r;
  logic signed [63:0] m2_b_r;
  side_t              m2_side_r;

  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic        m3_v_r;
  logic [32:0] m3_am_r;
  logic [32:0] m3_bm_r;
  side_t       m3_side_r;

  logic        m4_v_r;
  logic [31:0] m4_ahh_r;
  logic [32:0] m4_ahl_r;
  logic [33:0] m4_all_r;
  logic [31:0] m4_bhh_r;
  logic [32:0] m4_bhl_r;
  logic [33:0] m4_bll_r;
  side_t       m4_side_r;

  logic        m5_v_r;
  logic [65:0] m5_asq_r;
  logic [65:0] m5_bsq_r;
  side_t       m5_side_r;

  // Normalized terms.
  logic             ovf1;
  logic             ovf2;
  logic             t1_v;
  logic             t2_v;
  logic [47:0]      q1;
  logic [47:0]      q2;
  logic [TAG_T-1:0] t1_tag;
  logic [0:0]       t2_tag;
  logic             t_degen;
  logic [FW-1:0]    t_freq;
  logic             t_ovf1;
  logic [48:0]      t1;
  logic [48:0]      t2;
  logic [49:0]      sum;
  logic             clip;

  logic                          out_v_r;
  logic [lsbp_pkg::POW_W-1:0]    out_power_r;
  logic [FW-1:0]                 out_freq_r;
  logic                          out_degen_r;
  logic                          out_sat_r;

  assign en = !out_v_r || out_ready;
  assign q_pop = en && q_valid;

  lsbp_sqrt_pipe #(.W(64), .TW(TAG_H)) u_mag (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q_valid),
    .in_x     (q_item.wr_sq + q_item.wi_sq),
    .in_tag   ({q_item.bin_bad, q_item.freq, q_item.wr_neg, q_item.wi, q_item.dr,
                q_item.di}),
    .out_valid(h_v),
    .out_root (h),
    .out_tag  (h_tag)
  );

  assign {h_bad, h_freq, h_neg, h_wi, h_dr, h_di} = h_tag;

  assign n16 = {sample_count, 16'd0};
  assign d1w = {1'b0, n16} + {1'b0, h};
  assign d2w = {2'b0, n16} - {2'b0, h};
  assign xc = {2'b0, h} + {{2{h_wi[DW-1]}}, h_wi};
  assign xs = {2'b0, h} - {{2{h_wi[DW-1]}}, h_wi};
  assign degen = h_bad || (h == '0) || (d1w == '0) || d2w[33] || (d2w == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_xc_r <= xc[32:0];
      b_xs_r <= xs[32:0];
      b_den_r <= {h, 1'b0};
      b_side_r.degen <= degen;
      b_side_r.freq <= h_freq;
      b_side_r.d1 <= d1w;
      b_side_r.d2 <= d2w[32:0];
      b_neg_r <= h_neg;
      b_dr_r <= h_dr;
      b_di_r <= h_di;
    end
  end

  lsbp_div_pipe #(.DW(33), .QW(31), .TW(TAG_C)) u_div_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .in_rem   ({1'b0, b_xc_r[32:1]}),
    .in_low   ({b_xc_r[0], 30'd0}),
    .in_den   (b_den_r),
    .in_tag   ({b_dr_r, b_di_r}),
    .out_valid(qc_v),
    .out_quot (qc),
    .out_tag  (qc_tag)
  );

  lsbp_div_pipe #(.DW(33), .QW(31), .TW(TAG_S)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .in_rem   ({1'b0, b_xs_r[32:1]}),
    .in_low   ({b_xs_r[0], 30'd0}),
    .in_den   (b_den_r),
    .in_tag   ({b_neg_r, b_side_r}),
    .out_valid(qs_v),
    .out_quot (qs),
    .out_tag  (qs_tag)
  );

  lsbp_sqrt_pipe #(.W(62), .TW(TAG_C)) u_root_c (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (qc_v),
    .in_x     ({1'b0, qc, 30'd0}),
    .in_tag   (qc_tag),
    .out_valid(rc_v),
    .out_root (cwt),
    .out_tag  (rc_tag)
  );

  lsbp_sqrt_pipe #(.W(62), .TW(TAG_S)) u_root_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (qs_v),
    .in_x     ({1'b0, qs, 30'd0}),
    .in_tag   (qs_tag),
    .out_valid(rs_v),
    .out_root (swt),
    .out_tag  (rs_tag)
  );

  assign {r_dr, r_di} = rc_tag;
  assign {r_neg, r_side} = rs_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      m5_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= rc_v && rs_v;
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
    end
  end

  assign a_mag = m2_a_r[63] ? 64'd0 - $unsigned(m2_a_r) : $unsigned(m2_a_r);
  assign b_mag = m2_b_r[63] ? 64'd0 - $unsigned(m2_b_r) : $unsigned(m2_b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_p1_r <= $signed({1'b0, cwt}) * r_dr;
      m1_p2_r <= $signed({1'b0, swt}) * r_di;
      m1_p3_r <= $signed({1'b0, cwt}) * r_di;
      m1_p4_r <= $signed({1'b0, swt}) * r_dr;
      m1_neg_r <= r_neg;
      m1_side_r <= r_side;

      m2_a_r <= m1_neg_r ? m1_p1_r - m1_p2_r : m1_p1_r + m1_p2_r;
      m2_b_r <= m1_neg_r ? m1_p3_r + m1_p4_r : m1_p3_r - m1_p4_r;
      m2_side_r <= m1_side_r;

      m3_am_r <= a_mag[62:30];
      m3_bm_r <= b_mag[62:30];
      m3_side_r <= m2_side_r;

      m4_ahh_r <= m3_am_r[32:17] * m3_am_r[32:17];
      m4_ahl_r <= {1'b0, m3_am_r[32:17]} * m3_am_r[16:0];
      m4_all_r <= {17'd0, m3_am_r[16:0]} * {17'd0, m3_am_r[16:0]};
      m4_bhh_r <= m3_bm_r[32:17] * m3_bm_r[32:17];
      m4_bhl_r <= {1'b0, m3_bm_r[32:17]} * m3_bm_r[16:0];
      m4_bll_r <= {17'd0, m3_bm_r[16:0]} * {17'd0, m3_bm_r[16:0]};
      m4_side_r <= m3_side_r;

      m5_asq_r <= {m4_ahh_r, 34'd0} + {15'd0, m4_ahl_r, 18'd0} + {32'd0, m4_all_r};
      m5_bsq_r <= {m4_bhh_r, 34'd0} + {15'd0, m4_bhl_r, 18'd0} + {32'd0, m4_bll_r};
      m5_side_r <= m4_side_r;
    end
  end

  // A quotient of 2^48 or more is clipped, so only the low 48 quotient bits are divided out.
  assign ovf1 = ({15'd0, m5_asq_r[65:48]} >= m5_side_r.d1);
  assign ovf2 = ({15'd0, m5_bsq_r[65:48]} >= m5_side_r.d2);

  lsbp_div_pipe #(.DW(33), .QW(48), .TW(TAG_T)) u_term_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m5_v_r),
    .in_rem   (ovf1 ? 33'd0 : {15'd0, m5_asq_r[65:48]}),
    .in_low   (m5_asq_r[47:0]),
    .in_den   (m5_side_r.d1),
    .in_tag   ({m5_side_r.degen, m5_side_r.freq, ovf1}),
    .out_valid(t1_v),
    .out_quot (q1),
    .out_tag  (t1_tag)
  );

  lsbp_div_pipe #(.DW(33), .QW(48), .TW(1)) u_term_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m5_v_r),
    .in_rem   (ovf2 ? 33'd0 : {15'd0, m5_bsq_r[65:48]}),
    .in_low   (m5_bsq_r[47:0]),
    .in_den   (m5_side_r.d2),
    .in_tag   (ovf2),
    .out_valid(t2_v),
    .out_quot (q2),
    .out_tag  (t2_tag)
  );

  assign {t_degen, t_freq, t_ovf1} = t1_tag;
  assign t1 = t_ovf1 ? TERM_MAX : {1'b0, q1};
  assign t2 = t2_tag[0] ? TERM_MAX : {1'b0, q2};
  assign sum = {1'b0, t1} + {1'b0, t2};
  assign clip = (sum[49:48] != 2'b00);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= t1_v && t2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_freq_r <= t_freq;
      out_degen_r <= t_degen;
      out_sat_r <= !t_degen && clip;
      if (t_degen) begin
        out_power_r <= '0;
      end else if (clip) begin
        out_power_r <= '1;
      end else begin
        out_power_r <= sum[47:0];
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_power = out_power_r;
  assign out_freq = out_freq_r;
  assign out_degen = out_degen_r;
  assign out_sat = out_sat_r;

endmodule

>>> design/lomb_scargle_bin_power_core.sv
`timescale 1ns / 1ps
// Top level of the Lomb-Scargle per-bin power core with its configuration registers.
//
// The core takes one bin per clock while its input is not stalled and returns one result
// beat per input beat, in order. Each result passes through the bit-per-stage square
// root and divider pipelines (window magnitude, angle quotients, their roots and the
// two normalized terms). The whole back pipeline halts while a finished result waits on
// the output; the input stage and a four-entry queue still take up to five more beats
// before the input stalls as well. Configuration must be written only while the core
// holds no bins in flight; the core itself does not enforce this.
module lomb_scargle_bin_power_core #(
  parameter int QUEUE_DEPTH = lsbp_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // bin_index[15:0], data_re[47:16], data_im[79:48], win_re[111:80], win_im[143:112]
  input  logic [lsbp_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // power[47:0], frequency[95:48]
  output logic [lsbp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // degenerate[0], saturated[1]
  output logic [lsbp_pkg::OUT_TUSER_W-1:0]     out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsbp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lsbp_pkg::STEP_W-1:0]          cfg_data
);

  logic [lsbp_pkg::CNT_W-1:0]   sample_count_r;
  logic [lsbp_pkg::STEP_W-1:0]  freq_step_r;
  logic                         q_valid;
  logic                         q_pop;
  lsbp_pkg::fe_item_t           q_item;
  logic [lsbp_pkg::POW_W-1:0]   power;
  logic [lsbp_pkg::FREQ_W-1:0]  freq;
  logic                         degen;
  logic                         sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= lsbp_pkg::SAMPLE_COUNT_RST;
      freq_step_r <= lsbp_pkg::FREQ_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lsbp_pkg::CFG_SAMPLE_COUNT: begin
          sample_count_r <= cfg_data[lsbp_pkg::CNT_W-1:0];
        end
        lsbp_pkg::CFG_FREQ_STEP: begin
          freq_step_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  lsbp_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_bin   (in_tdata[15:0]),
    .in_dr    ($signed(in_tdata[47:16])),
    .in_di    ($signed(in_tdata[79:48])),
    .in_wr    ($signed(in_tdata[111:80])),
    .in_wi    ($signed(in_tdata[143:112])),
    .freq_step(freq_step_r),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lsbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .sample_count(sample_count_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_power   (power),
    .out_freq    (freq),
    .out_degen   (degen),
    .out_sat     (sat)
  );

  assign out_tdata = {freq, power};
  assign out_tuser = {sat, degen};

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the Lomb-Scargle bin power core with a built-in power predictor.
module tb_top;

  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned LIMIT48 = 64'h1_0000_0000_0000;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [lsbp_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'd5;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [31:0] wi;
    logic signed [31:0] wr;
    logic signed [31:0] di;
    logic signed [31:0] dr;
    logic [15:0] bin;
  } bin_beat_t;

  typedef struct packed {
    logic [47:0] power;
    logic [47:0] freq;
    logic degen;
    logic sat;
  } power_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lsbp_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lsbp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [lsbp_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lsbp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lsbp_pkg::STEP_W-1:0] cfg_data = '0;

  bin_beat_t pending_bins[$];
  power_res_t expected_powers[$];
  logic [15:0] n_count = lsbp_pkg::SAMPLE_COUNT_RST;
  logic [31:0] df_step = lsbp_pkg::FREQ_STEP_RST;
  int errors = 0;
  int idle_pct = 13;
  int stall_cycles = 0;

  lomb_scargle_bin_power_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic power_res_t predict_power(bin_beat_t it);
    power_res_t res;
    longint signed dr, di, wr, wi, h, d1, d2, cwt, swt, a, b;
    longint unsigned qc, qs, am, bm, t1, t2, pw;
    dr = it.dr;
    di = it.di;
    wr = it.wr;
    wi = it.wi;
    res = '0;
    h = floor_sqrt(wr * wr + wi * wi);
    d1 = (longint'(n_count) <<< 16) + h;
    d2 = (longint'(n_count) <<< 16) - h;
    res.freq = 48'((64'(it.bin) * 64'(df_step)) & MASK48);
    if (it.bin == 0 || it.bin > lsbp_pkg::MAX_BINS || h == 0 || d1 <= 0 || d2 <= 0) begin
      res.degen = 1'b1;
    end else begin
      qc = (u64_t'(h + wi) << 30) / u64_t'(2 * h);
      qs = (u64_t'(h - wi) << 30) / u64_t'(2 * h);
      cwt = floor_sqrt(qc << 30);
      swt = floor_sqrt(qs << 30);
      if (wr < 0) swt = -swt;
      a = cwt * dr + swt * di;
      b = cwt * di - swt * dr;
      am = (a < 0 ? -a : a) >> 30;
      bm = (b < 0 ? -b : b) >> 30;
      t1 = (am * am) / u64_t'(d1);
      t2 = (bm * bm) / u64_t'(d2);
      if (t1 > LIMIT48) t1 = LIMIT48;
      if (t2 > LIMIT48) t2 = LIMIT48;
      pw = t1 + t2;
      if (pw > MASK48) begin
        pw = MASK48;
        res.sat = 1'b1;
      end
      res.power = pw[47:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_powers.push_back(predict_power(in_tdata));
    end
    if (!in_tvalid || in_tready) begin
      if (pending_bins.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tdata <= pending_bins.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    power_res_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_powers.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[47:0], 0);
      end else begin
        exp_res = expected_powers.pop_front();
        if (out_tdata[47:0] !== exp_res.power)
          report_mismatch("power", out_tdata[47:0], exp_res.power);
        if (out_tdata[95:48] !== exp_res.freq)
          report_mismatch("frequency", out_tdata[95:48], exp_res.freq);
        if (out_tuser[0] !== exp_res.degen)
          report_mismatch("degenerate", out_tuser[0], exp_res.degen);
        if (out_tuser[1] !== exp_res.sat)
          report_mismatch("saturated", out_tuser[1], exp_res.sat);
      end
    end
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [lsbp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lsbp_pkg::CFG_SAMPLE_COUNT) n_count = val[15:0];
    else if (idx == lsbp_pkg::CFG_FREQ_STEP) df_step = val;
  endtask

  task automatic wait_idle();
    while (pending_bins.size() > 0 || in_tvalid || expected_powers.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_bin(logic [15:0] bin, logic [31:0] dr, logic [31:0] di,
                         logic [31:0] wr, logic [31:0] wi);
    bin_beat_t it;
    it.bin = bin;
    it.dr = dr;
    it.di = di;
    it.wr = wr;
    it.wi = wi;
    pending_bins.push_back(it);
  endtask

  task automatic add_random_bins(int count);
    logic [31:0] wr, wi;
    for (int i = 0; i < count; i++) begin
      wr = $urandom;
      wi = $urandom;
      if ($urandom_range(3) != 0) begin
        wr = $signed(wr) >>> $urandom_range(31, 8);
        wi = $signed(wi) >>> $urandom_range(31, 8);
      end
      add_bin(($urandom_range(19) == 0) ? 16'($urandom_range(1)) * 16'hFFFF
                                        : 16'($urandom_range(65535)),
              $urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
              ($urandom_range(29) == 0) ? 32'd0 : wr,
              ($urandom_range(29) == 0) ? 32'd0 : wi);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_bin(16'd1, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    add_bin(16'd0, 32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0);
    add_bin(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 32'h0000_4000);
    add_bin(16'd5, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0);
    add_bin(16'd7, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0000_8000);
    add_bin(16'd9, 32'h0003_0000, 32'h0001_0000, 32'h8000_0000, 32'h0);
    add_bin(16'd11, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_C000, 32'h0000_2000);
    wait_idle();
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, 32'd1);
    write_reg(CFG_NO_REG, 32'h1234);
    add_bin(16'd3, 32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0);
    wait_idle();
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, 32'hFFFF);
    write_reg(lsbp_pkg::CFG_FREQ_STEP, 32'hFFFF_FFFF);
    add_bin(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
    add_bin(16'd2, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0000_0001);
    add_bin(16'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_random_bins(400);
    wait_idle();
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, 32'd2);
    write_reg(lsbp_pkg::CFG_FREQ_STEP, 32'd0);
    add_random_bins(400);
    wait_idle();
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, $urandom_range(65535, 2));
    write_reg(lsbp_pkg::CFG_FREQ_STEP, $urandom);
    idle_pct = 0;
    add_random_bins(400);
    wait_idle();
    idle_pct = 13;
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, 32'd0);
    add_random_bins(40);
    wait_idle();
    write_reg(lsbp_pkg::CFG_SAMPLE_COUNT, $urandom_range(300, 2));
    write_reg(lsbp_pkg::CFG_FREQ_STEP, 32'd65536);
    add_random_bins(400);
    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
